// File: sv/edge_triggered_scope_capture_macros.svh
// Assertion macros for the edge-triggered scope capture block.
`ifndef EDGE_TRIGGERED_SCOPE_CAPTURE_MACROS_SVH
`define EDGE_TRIGGERED_SCOPE_CAPTURE_MACROS_SVH

// Same-cycle implication, reset disables the check.
`define ETSC_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, reset disables the check.
`define ETSC_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: sv/etsc_pkg.sv
// Package with shared constants, item types and helpers of the scope capture block.
`timescale 1ns / 1ps

package etsc_pkg;

   localparam int RING_DEPTH = 8192;
   localparam int DISP_DEPTH = 1024;
   localparam int RING_AW    = $clog2(RING_DEPTH);
   localparam int DISP_AW    = $clog2(DISP_DEPTH);
   localparam int PIX_W      = 16;

   localparam logic [2:0] CSR_TRIG_MODE  = 3'd0;
   localparam logic [2:0] CSR_TRIG_LEVEL = 3'd1;
   localparam logic [2:0] CSR_GAIN       = 3'd2;
   localparam logic [2:0] CSR_WIDTH      = 3'd3;
   localparam logic [2:0] CSR_HEIGHT     = 3'd4;
   localparam logic [2:0] CSR_OFFSET     = 3'd5;
   localparam logic [2:0] CSR_PRETRIG    = 3'd6;

   localparam logic [1:0] MODE_RISE = 2'd1;
   localparam logic [1:0] MODE_FALL = 2'd2;

   localparam logic KIND_READ = 1'b1;

   typedef struct packed {
      logic              kind;
      logic signed [15:0] sample;
      logic [9:0]        column;
   } req_type;

   typedef struct packed {
      logic              frame_done;
      logic signed [15:0] pixel_row;
   } rsp_type;

   function automatic logic signed [15:0] sat16(input logic signed [32:0] v);
      logic signed [15:0] r;
      if (v > 33'sd32767) begin
         r = 16'sh7fff;
      end else if (v < -33'sd32768) begin
         r = 16'sh8000;
      end else begin
         r = v[15:0];
      end
      return r;
   endfunction

endpackage

// File: sv/etsc_ram.sv
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps

module etsc_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// File: sv/etsc_conv.sv
// Sample scaling and pixel row conversion pipeline.
`timescale 1ns / 1ps

module etsc_conv import etsc_pkg::*; (
   input  logic               clock,
   input  logic signed [15:0] sample,
   input  logic [15:0]        gain,
   input  logic [11:0]        height,
   input  logic [11:0]        offset,
   output logic signed [15:0] scaled,
   output logic signed [15:0] row
);

   logic signed [32:0] p_ff, p_in;
   logic signed [15:0] scaled_ff, scaled_in;
   logic signed [27:0] prod_ff, prod_in;
   logic signed [15:0] row_ff, row_in;
   logic signed [31:0] num;
   logic signed [31:0] num_adj;
   logic signed [31:0] quo;

   assign p_in      = sample * $signed({1'b0, gain});
   assign scaled_in = sat16(p_ff >>> 12);
   assign prod_in   = scaled_ff * $signed({1'b0, height});

   // truncate toward zero
   assign num     = $signed({2'b00, offset, 18'd0}) - 32'(prod_ff);
   assign num_adj = num[31] ? (num + 32'sd262143) : num;
   assign quo     = num_adj >>> 18;
   assign row_in  = sat16(33'(quo));

   always_ff @(posedge clock) begin
      p_ff      <= p_in;
      scaled_ff <= scaled_in;
      prod_ff   <= prod_in;
      row_ff    <= row_in;
   end

   assign scaled = scaled_ff;
   assign row    = row_ff;

endmodule

// File: sv/edge_triggered_scope_capture.sv
// Top level of the edge-triggered scope capture block.
//
// Input channel req_* carries one item: a sample (kind 0) or a display column
// read (kind 1). Result channel rsp_* returns one item per input item:
// frame_done and pixel_row. Configuration goes through csr_we, csr_index and
// csr_wdata, one register per write. The user must write only while the block
// is idle; the block itself does not enforce it. A sample item passes through
// scaling multiply, saturation, trigger check and height multiply, row rounding
// and ring write. When the sample completes a frame, the copy of screen_width
// rows from the ring into the display store follows, one ring read a cycle.
// A column read goes through the display store read port.
// One item is in flight at a time; req_stall is high while it is.
// The next item can be accepted in the cycle after the result register loads.
// After reset the block sweeps both stores to zero, one ring entry a cycle,
// with req_stall high; configuration writes are still taken.
// The result sits in an output register; while rsp_stall holds it, the next
// item may already be accepted and waits only to hand over its result.
`timescale 1ns / 1ps
`include "edge_triggered_scope_capture_macros.svh"

module edge_triggered_scope_capture import etsc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   localparam logic [3:0] S_CLEAR = 4'd0;
   localparam logic [3:0] S_IDLE  = 4'd1;
   localparam logic [3:0] S_SCALE = 4'd2;
   localparam logic [3:0] S_SAT   = 4'd3;
   localparam logic [3:0] S_TRIG  = 4'd4;
   localparam logic [3:0] S_ROW   = 4'd5;
   localparam logic [3:0] S_STORE = 4'd6;
   localparam logic [3:0] S_COPY  = 4'd7;
   localparam logic [3:0] S_DRAIN = 4'd8;
   localparam logic [3:0] S_DONE  = 4'd9;
   localparam logic [3:0] S_RADDR = 4'd10;
   localparam logic [3:0] S_RRESP = 4'd11;

   logic [3:0]         state_ff, state_in;
   logic [RING_AW-1:0] clr_ff, clr_in;
   logic [RING_AW-1:0] wp_ff, wp_in;
   logic [RING_AW-1:0] rp_ff, rp_in;
   logic [10:0]        cc_ff, cc_in;
   logic [10:0]        x_ff, x_in;
   logic [10:0]        pend_x_ff, pend_x_in;
   logic               pend_ff, pend_in;
   logic               trig_ff, trig_in;
   logic               done_ff, done_in;
   logic signed [15:0] prev_ff, prev_in;
   logic signed [15:0] sample_ff, sample_in;
   logic [9:0]         column_ff, column_in;

   logic [1:0]         mode_ff, mode_in;
   logic signed [15:0] level_ff, level_in;
   logic [15:0]        gain_ff, gain_in;
   logic [10:0]        width_ff, width_in;
   logic [11:0]        height_ff, height_in;
   logic [11:0]        offset_ff, offset_in;
   logic [10:0]        pretrig_ff, pretrig_in;

   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;

   logic               ring_we;
   logic [RING_AW-1:0] ring_waddr;
   logic [PIX_W-1:0]   ring_wdata;
   logic [PIX_W-1:0]   ring_rdata;
   logic               disp_we;
   logic [DISP_AW-1:0] disp_waddr;
   logic [PIX_W-1:0]   disp_wdata;
   logic [PIX_W-1:0]   disp_rdata;

   logic signed [15:0] scaled;
   logic signed [15:0] row;
   logic               out_free;
   logic               hit;
   logic [10:0]        cc_inc;

   etsc_conv u_conv (
      .clock  (clock),
      .sample (sample_ff),
      .gain   (gain_ff),
      .height (height_ff),
      .offset (offset_ff),
      .scaled (scaled),
      .row    (row)
   );

   etsc_ram #(.WIDTH(PIX_W), .DEPTH(RING_DEPTH)) u_ring (
      .clock (clock),
      .we    (ring_we),
      .waddr (ring_waddr),
      .wdata (ring_wdata),
      .raddr (rp_ff),
      .rdata (ring_rdata)
   );

   etsc_ram #(.WIDTH(PIX_W), .DEPTH(DISP_DEPTH)) u_disp (
      .clock (clock),
      .we    (disp_we),
      .waddr (disp_waddr),
      .wdata (disp_wdata),
      .raddr (DISP_AW'(column_ff)),
      .rdata (disp_rdata)
   );

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign cc_inc   = cc_ff + 11'd1;

   always_comb begin
      hit = 1'b0;
      unique case (mode_ff)
         MODE_RISE: hit = (prev_ff < level_ff) && (scaled >= level_ff);
         MODE_FALL: hit = (prev_ff > level_ff) && (scaled <= level_ff);
         default:   hit = 1'b0;
      endcase
   end

   always_comb begin
      mode_in    = mode_ff;
      level_in   = level_ff;
      gain_in    = gain_ff;
      width_in   = width_ff;
      height_in  = height_ff;
      offset_in  = offset_ff;
      pretrig_in = pretrig_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_TRIG_MODE:  mode_in    = csr_wdata[1:0];
            CSR_TRIG_LEVEL: level_in   = csr_wdata;
            CSR_GAIN:       gain_in    = csr_wdata;
            CSR_WIDTH:      width_in   = csr_wdata[10:0];
            CSR_HEIGHT:     height_in  = csr_wdata[11:0];
            CSR_OFFSET:     offset_in  = csr_wdata[11:0];
            CSR_PRETRIG:    pretrig_in = csr_wdata[10:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      wp_in        = wp_ff;
      rp_in        = rp_ff;
      cc_in        = cc_ff;
      x_in         = x_ff;
      pend_x_in    = pend_x_ff;
      pend_in      = 1'b0;
      trig_in      = trig_ff;
      done_in      = done_ff;
      prev_in      = prev_ff;
      sample_in    = sample_ff;
      column_in    = column_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      req_stall    = (state_ff != S_IDLE);
      ring_we      = 1'b0;
      ring_waddr   = wp_ff;
      ring_wdata   = row;
      disp_we      = 1'b0;
      disp_waddr   = DISP_AW'(pend_x_ff);
      disp_wdata   = ring_rdata;

      unique case (state_ff)
         S_CLEAR: begin
            ring_we    = 1'b1;
            ring_waddr = clr_ff;
            ring_wdata = '0;
            disp_we    = (32'(clr_ff) < DISP_DEPTH);
            disp_waddr = DISP_AW'(clr_ff);
            disp_wdata = '0;
            clr_in     = clr_ff + RING_AW'(1);
            if (32'(clr_ff) == RING_DEPTH - 1) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               sample_in = req_data.sample;
               column_in = req_data.column;
               state_in  = (req_data.kind == KIND_READ) ? S_RADDR : S_SCALE;
            end
         end
         S_SCALE: state_in = S_SAT;
         S_SAT:   state_in = S_TRIG;
         S_TRIG: begin
            if (hit && !trig_ff) begin
               trig_in = 1'b1;
               cc_in   = '0;
               rp_in   = wp_ff - RING_AW'(pretrig_ff);
            end
            prev_in  = scaled;
            state_in = S_ROW;
         end
         S_ROW: state_in = S_STORE;
         S_STORE: begin
            ring_we = 1'b1;
            wp_in   = wp_ff + RING_AW'(1);
            if (cc_inc >= width_ff) begin
               trig_in  = 1'b0;
               cc_in    = '0;
               x_in     = '0;
               done_in  = 1'b1;
               state_in = (width_ff == 11'd0) ? S_DONE : S_COPY;
            end else begin
               cc_in    = cc_inc;
               done_in  = 1'b0;
               state_in = S_DONE;
            end
         end
         S_COPY: begin
            disp_we   = pend_ff && (32'(pend_x_ff) < DISP_DEPTH);
            rp_in     = rp_ff + RING_AW'(1);
            x_in      = x_ff + 11'd1;
            pend_in   = 1'b1;
            pend_x_in = x_ff;
            if (x_ff == width_ff - 11'd1) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            disp_we  = pend_ff && (32'(pend_x_ff) < DISP_DEPTH);
            state_in = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in          = 1'b1;
               rsp_data_in.frame_done = done_ff;
               rsp_data_in.pixel_row  = '0;
               state_in              = S_IDLE;
            end
         end
         S_RADDR: state_in = S_RRESP;
         S_RRESP: begin
            if (out_free) begin
               rsp_valid_in           = 1'b1;
               rsp_data_in.frame_done = 1'b0;
               rsp_data_in.pixel_row  = (32'(column_ff) < DISP_DEPTH) ?
                                        $signed(disp_rdata) : 16'sd0;
               state_in               = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         wp_ff        <= '0;
         rp_ff        <= '0;
         cc_ff        <= '0;
         x_ff         <= '0;
         pend_ff      <= 1'b0;
         trig_ff      <= 1'b0;
         done_ff      <= 1'b0;
         prev_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         mode_ff      <= 2'd0;
         level_ff     <= '0;
         gain_ff      <= 16'd4096;
         width_ff     <= 11'd1024;
         height_ff    <= 12'd256;
         offset_ff    <= 12'd128;
         pretrig_ff   <= 11'd512;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         wp_ff        <= wp_in;
         rp_ff        <= rp_in;
         cc_ff        <= cc_in;
         x_ff         <= x_in;
         pend_ff      <= pend_in;
         trig_ff      <= trig_in;
         done_ff      <= done_in;
         prev_ff      <= prev_in;
         rsp_valid_ff <= rsp_valid_in;
         mode_ff      <= mode_in;
         level_ff     <= level_in;
         gain_ff      <= gain_in;
         width_ff     <= width_in;
         height_ff    <= height_in;
         offset_ff    <= offset_in;
         pretrig_ff   <= pretrig_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_x_ff   <= pend_x_in;
      sample_ff   <= sample_in;
      column_ff   <= column_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `ETSC_ASSERT_IMP(a_ring_write_src, clock, reset, ring_we,
      (state_ff == S_STORE) || (state_ff == S_CLEAR), "ring written outside store or clear")
   `ETSC_ASSERT_NXT(a_wp_advance, clock, reset, state_ff == S_STORE,
      wp_ff == $past(wp_ff) + RING_AW'(1), "write pointer did not advance by one")
   `ETSC_ASSERT_NXT(a_frame_disarm, clock, reset,
      (state_ff == S_DONE) && out_free && done_ff,
      rsp_valid_ff && rsp_data_ff.frame_done && !trig_ff && (cc_ff == 11'd0),
      "frame result without disarm")

endmodule

// File: tb/tb.sv
// Testbench for the edge-triggered scope capture block: self-checking scoreboard and stimulus.
`timescale 1ns / 1ps

import etsc_pkg::*;

class scope_scoreboard;
   bit signed [15:0] ring_rows [RING_DEPTH];
   bit signed [15:0] shown_rows [DISP_DEPTH];
   bit signed [15:0] last_scaled;
   bit               armed;
   bit [10:0]        columns_seen;
   bit [RING_AW-1:0] write_ptr;
   bit [RING_AW-1:0] read_ptr;

   bit [1:0]         mode = 2'd0;
   bit signed [15:0] level = 16'sd0;
   bit [15:0]        gain = 16'd4096;
   bit [10:0]        width = 11'd1024;
   bit [11:0]        height = 12'd256;
   bit [11:0]        offset = 12'd128;
   bit [10:0]        pretrig = 11'd512;

   rsp_type          awaited_rsp [$];
   int               errors;

   static function bit signed [15:0] clamp16(longint v);
      if (v > 32767) return 16'sh7fff;
      if (v < -32768) return 16'sh8000;
      return v[15:0];
   endfunction

   function void write_reg(logic [2:0] idx, logic [15:0] data);
      case (idx)
         CSR_TRIG_MODE:  mode = data[1:0];
         CSR_TRIG_LEVEL: level = data;
         CSR_GAIN:       gain = data;
         CSR_WIDTH:      width = data[10:0];
         CSR_HEIGHT:     height = data[11:0];
         CSR_OFFSET:     offset = data[11:0];
         CSR_PRETRIG:    pretrig = data[10:0];
         default: ;
      endcase
   endfunction

   function bit signed [15:0] scale(bit signed [15:0] s);
      bit signed [32:0] prod;
      prod = s * $signed({1'b0, gain});
      return clamp16(longint'(prod >>> 12));
   endfunction

   function bit signed [15:0] pixel_of(bit signed [15:0] scaled);
      longint num;
      num = longint'(offset) * 262144 - longint'(scaled) * longint'(height);
      return clamp16(num / 262144);
   endfunction

   function bit capture_sample(bit signed [15:0] s);
      bit signed [15:0] scaled;
      bit               hit;
      int               x;
      scaled = scale(s);
      hit = 1'b0;
      if (mode == MODE_RISE) begin
         hit = (last_scaled < level) && (scaled >= level);
      end else if (mode == MODE_FALL) begin
         hit = (last_scaled > level) && (scaled <= level);
      end
      if (hit && !armed) begin
         armed = 1'b1;
         columns_seen = '0;
         read_ptr = write_ptr - RING_AW'(pretrig);
      end
      last_scaled = scaled;
      ring_rows[write_ptr] = pixel_of(scaled);
      write_ptr++;
      columns_seen++;
      if (columns_seen >= width) begin
         armed = 1'b0;
         columns_seen = '0;
         for (x = 0; x < width; x++) begin
            if (x < DISP_DEPTH) shown_rows[x] = ring_rows[read_ptr];
            read_ptr++;
         end
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function void note_item(req_type it);
      rsp_type r;
      r = '0;
      if (it.kind == KIND_READ) begin
         r.pixel_row = shown_rows[it.column];
      end else begin
         r.frame_done = capture_sample(it.sample);
      end
      awaited_rsp.push_back(r);
   endfunction

   task report_mismatch(string what);
      errors++;
      if (errors <= 50) $display("mismatch: %s", what);
   endtask

   task check_result(rsp_type got);
      rsp_type want;
      if (awaited_rsp.size() == 0) begin
         report_mismatch("result with no item awaiting it");
         return;
      end
      want = awaited_rsp.pop_front();
      if (got.frame_done !== want.frame_done)
         report_mismatch($sformatf("frame_done got %0d want %0d",
                                   got.frame_done, want.frame_done));
      if (got.pixel_row !== want.pixel_row)
         report_mismatch($sformatf("pixel_row got %0d want %0d",
                                   got.pixel_row, want.pixel_row));
   endtask
endclass

module tb;

   localparam logic [1:0] MODE_FREE   = 2'd0;
   localparam logic [1:0] MODE_UNDEF  = 2'd3;
   localparam logic       KIND_SAMPLE = 1'b0;
   localparam logic [2:0] CSR_SPARE   = 3'd7;
   localparam int HOLD_CYCLES  = 300;
   localparam int STALL_LIMIT  = 40000;
   localparam int SETTLE_CYCLES = 20;

   typedef struct {
      bit [1:0]         mode;
      bit signed [15:0] level;
      bit [15:0]        gain;
      bit [10:0]        width;
      bit [11:0]        height;
      bit [11:0]        offset;
      bit [10:0]        pretrig;
   } scope_setup_type;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsp_type     rsp_data;
   logic        csr_we = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [15:0] csr_wdata = '0;

   scope_scoreboard board = new;
   req_type         sample_queue [$];
   bit              offering;
   int              send_idle_pct;
   int              recv_stall_pct;
   bit              hold_request;
   int              hold_left;
   int              quiet_cycles;

   edge_triggered_scope_capture dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            board.note_item(req_data);
            offering = 1'b0;
         end
         if (!req_valid || !req_stall) begin
            if (sample_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               req_valid <= 1'b1;
               req_data <= sample_queue.pop_front();
               offering = 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) board.check_result(rsp_data);
      if (hold_request) begin
         hold_request = 1'b0;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   task automatic write_csr(logic [2:0] idx, logic [15:0] value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      board.write_reg(idx, value);
      @(posedge clock);
   endtask

   task automatic apply_setup(scope_setup_type s);
      write_csr(CSR_TRIG_MODE, 16'(s.mode));
      write_csr(CSR_TRIG_LEVEL, s.level);
      write_csr(CSR_GAIN, s.gain);
      write_csr(CSR_WIDTH, 16'(s.width));
      write_csr(CSR_HEIGHT, 16'(s.height));
      write_csr(CSR_OFFSET, 16'(s.offset));
      write_csr(CSR_PRETRIG, 16'(s.pretrig));
      csr_we <= 1'b0;
   endtask

   task automatic wait_drained();
      while (sample_queue.size() != 0 || offering || board.awaited_rsp.size() != 0)
         @(posedge clock);
   endtask

   task automatic push_sample(bit signed [15:0] v);
      req_type it;
      it = '0;
      it.kind = KIND_SAMPLE;
      it.sample = v;
      sample_queue.push_back(it);
   endtask

   task automatic push_read(bit [9:0] c);
      req_type it;
      it = '0;
      it.kind = KIND_READ;
      it.column = c;
      sample_queue.push_back(it);
   endtask

   function automatic scope_setup_type random_setup();
      scope_setup_type s;
      s.mode = 2'($urandom_range(0, 3));
      s.level = ($urandom_range(0, 1) != 0) ? 16'($urandom) : 16'($urandom_range(0, 16384) - 8192);
      case ($urandom_range(0, 4))
         0: s.gain = 16'd0;
         1: s.gain = 16'hffff;
         2: s.gain = 16'($urandom);
         default: s.gain = 16'($urandom_range(1024, 16384));
      endcase
      s.width = ($urandom_range(0, 9) < 8) ? 11'($urandom_range(0, 24))
                                           : 11'($urandom_range(25, 300));
      s.height = 12'($urandom);
      s.offset = 12'($urandom);
      s.pretrig = ($urandom_range(0, 1) != 0) ? 11'($urandom_range(0, 32)) : 11'($urandom);
      return s;
   endfunction

   task automatic queue_random_items(int count, scope_setup_type s);
      req_type it;
      int      pick;
      int      top;
      longint  center;
      center = (s.gain == 0) ? 0 : longint'(s.level) * 4096 / longint'(s.gain);
      top = (s.width == 0) ? 0 : ((s.width > DISP_DEPTH) ? DISP_DEPTH - 1 : s.width - 1);
      repeat (count) begin
         it = '0;
         pick = $urandom_range(0, 99);
         if (pick < 25) begin
            it.kind = KIND_READ;
            it.column = (pick < 18) ? 10'($urandom_range(0, top)) : 10'($urandom);
         end else begin
            it.kind = KIND_SAMPLE;
            if (pick < 35) begin
               it.sample = 16'($urandom);
            end else if (pick < 40) begin
               case ($urandom_range(0, 3))
                  0: it.sample = 16'sh7fff;
                  1: it.sample = 16'sh8000;
                  2: it.sample = 16'sh0000;
                  default: it.sample = 16'shffff;
               endcase
            end else begin
               it.sample = board.clamp16(center + longint'($urandom_range(0, 6000)) - 3000);
            end
         end
         sample_queue.push_back(it);
      end
   endtask

   task automatic run_random_phases(int phases);
      scope_setup_type s;
      repeat (phases) begin
         s = random_setup();
         apply_setup(s);
         queue_random_items($urandom_range(30, 50), s);
         wait_drained();
      end
   endtask

   initial begin
      scope_setup_type s;
      send_idle_pct = 18;
      recv_stall_pct = 81;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      push_sample(16'sh7fff);
      push_sample(16'sh8000);
      push_sample(16'sh0000);
      push_sample(16'shffff);
      push_sample(16'sh0001);
      push_read(10'd0);
      push_read(10'd1023);
      wait_drained();

      write_csr(CSR_SPARE, 16'hffff);
      s = '{MODE_RISE, 16'sd0, 16'd4096, 11'd2, 12'd4095, 12'd4095, 11'd2047};
      apply_setup(s);
      push_sample(-16'sd100);
      push_sample(16'sd100);
      push_sample(16'sd200);
      push_sample(16'sd300);
      push_read(10'd0);
      push_read(10'd1);
      wait_drained();

      s = '{MODE_FALL, 16'sd0, 16'hffff, 11'd1, 12'd0, 12'd0, 11'd0};
      apply_setup(s);
      push_sample(16'sd100);
      push_sample(-16'sd100);
      push_sample(16'sh7fff);
      push_sample(16'sh8000);
      push_read(10'd0);
      wait_drained();

      s = '{MODE_UNDEF, 16'sh8000, 16'd0, 11'd0, 12'd1, 12'd2048, 11'd1};
      apply_setup(s);
      push_sample(16'sd5);
      push_sample(-16'sd5);
      push_read(10'd0);
      wait_drained();

      run_random_phases(5);

      send_idle_pct = 81;
      recv_stall_pct = 18;
      s = random_setup();
      s.mode = MODE_FALL;
      s.level = 16'sh7fff;
      s.width = 11'd2047;
      apply_setup(s);
      queue_random_items(30, s);
      wait_drained();
      run_random_phases(4);

      send_idle_pct = 0;
      recv_stall_pct = 0;
      s = random_setup();
      apply_setup(s);
      hold_request = 1'b1;
      queue_random_items(50, s);
      wait_drained();
      run_random_phases(3);

      s = random_setup();
      s.mode = MODE_FREE;
      s.width = 11'd24;
      apply_setup(s);
      repeat (30) push_sample(16'($urandom));
      push_read(10'd23);
      push_read(10'($urandom));
      wait_drained();

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (board.errors == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
